// ----- src/wfc_pkg.sv -----
package wfc_pkg;

    typedef logic [7:0]  char_t;
    typedef logic [15:0] count_t;

    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_PERIOD = 8'h2E;
    localparam char_t CH_NUL    = 8'h00;

    localparam count_t COUNT_MAX = 16'hFFFF;

    // register index taken from paddr[2]
    localparam logic REG_NUL_IS_DELIMITER = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    function automatic logic is_delim(input char_t c, input logic nul_on);
        logic d;
        d = (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_PERIOD);
        return d || ((c == CH_NUL) && nul_on);
    endfunction

    function automatic count_t sat_inc(input count_t c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

endpackage

// ----- src/wfc_table.sv -----
module wfc_table #(
    parameter int MAX_WORDS = 64,
    parameter int ROW_W     = 262
) (
    input  logic                         clk,
    input  logic [$clog2(MAX_WORDS)-1:0] rd_addr,
    input  logic                         row_we,
    input  logic [$clog2(MAX_WORDS)-1:0] row_waddr,
    input  logic [ROW_W-1:0]             row_wdata,
    input  logic                         cnt_we,
    input  logic [$clog2(MAX_WORDS)-1:0] cnt_waddr,
    input  wfc_pkg::count_t              cnt_wdata,
    output logic [ROW_W-1:0]             row_q,
    output wfc_pkg::count_t              cnt_q
);

    // each row holds {length, chars} of one stored word
    logic [ROW_W-1:0]   row_mem [MAX_WORDS];
    wfc_pkg::count_t    cnt_mem [MAX_WORDS];

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_q <= row_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[rd_addr];
    end

endmodule

// ----- src/wfc_compare.sv -----
module wfc_compare #(
    parameter int MAX_WORD_CHARS = 32,
    parameter int LW             = 6
) (
    input  logic [LW-1:0]                         row_len,
    input  logic [MAX_WORD_CHARS-1:0][7:0]        row_chars,
    input  logic [LW-1:0]                         cur_len,
    input  logic [MAX_WORD_CHARS-1:0][7:0]        cur_chars,
    output logic                                  hit
);

    logic [MAX_WORD_CHARS-1:0] byte_ok;

    // bytes past the word length are don't-care on both sides
    always_comb
    begin
        for (int k = 0; k < MAX_WORD_CHARS; k++)
        begin
            byte_ok[k] = (k >= int'(cur_len)) || (row_chars[k] == cur_chars[k]);
        end
    end

    assign hit = (row_len == cur_len) && (&byte_ok);

endmodule

// ----- src/word_frequency_counter_unit.sv -----
// a text byte is taken while idle and leaves the block idle; a delimiter that ends a word
// scans the stored entries (at most MAX_WORDS), one per cycle, keeping busy high so no
// new byte is taken until the scan ends, through the table read port and the shared row comparator
// the result beat is registered from the last lookup cycle and shows on done in the cycle after it
// rst_n clears table fill count, current word length and the nul delimiter register
// results cannot be stalled by the receiver
module word_frequency_counter_unit #(
    parameter int MAX_WORDS      = 64,
    parameter int MAX_WORD_CHARS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  char_code,
    input  logic        first_of_document,
    output logic        done,
    output logic [5:0]  word_index,
    output logic [15:0] word_count,
    output logic        is_new,
    output logic [6:0]  distinct_words,
    output logic        table_full,
    output logic        truncated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WIDX  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int UW    = $clog2(MAX_WORDS + 1);
    localparam int LW    = $clog2(MAX_WORD_CHARS + 1);
    localparam int CIW   = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
    localparam int ROW_W = LW + 8 * MAX_WORD_CHARS;

    wfc_pkg::state_t state_reg, state_next;
    logic [WIDX-1:0] scan_idx_reg, scan_idx_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [UW-1:0]   used_reg, used_next;
    logic            nul_reg;
    logic [MAX_WORD_CHARS-1:0][7:0] cur_word_reg;

    logic            done_reg;
    logic [WIDX-1:0] out_idx_reg;
    wfc_pkg::count_t out_cnt_reg;
    logic            out_new_reg;
    logic [UW-1:0]   out_used_reg;
    logic            out_full_reg;
    logic            out_trunc_reg;

    logic            accept;
    logic            clr;
    logic            delim;
    logic [LW-1:0]   len_eff;
    logic            ovf_eff;
    logic [UW-1:0]   used_eff;
    logic            room;
    logic [UW-1:0]   scan_nxt_cnt;

    logic            char_we;
    logic [WIDX-1:0] rd_addr;
    logic            row_we;
    logic            cnt_we;
    logic [WIDX-1:0] cnt_waddr;
    wfc_pkg::count_t cnt_wdata;
    logic [ROW_W-1:0] row_q;
    wfc_pkg::count_t cnt_q;
    logic            hit;

    logic            do_miss;
    logic            fin;
    logic [WIDX-1:0] fin_idx;
    wfc_pkg::count_t fin_cnt;
    logic            fin_new;
    logic            fin_full;

    logic [WIDX+6-1:0] idx_ext;
    logic [UW+7-1:0]   used_ext;

    assign accept   = start && !busy;
    assign busy     = (state_reg != wfc_pkg::ST_IDLE);
    assign clr      = accept && first_of_document;
    assign delim    = wfc_pkg::is_delim(char_code, nul_reg);
    assign len_eff  = clr ? '0 : len_reg;
    assign ovf_eff  = clr ? 1'b0 : ovf_reg;
    assign used_eff = clr ? '0 : used_reg;
    assign room     = (used_eff < UW'(MAX_WORDS));
    assign scan_nxt_cnt = UW'(scan_idx_reg) + UW'(1);

    wfc_table #(
        .MAX_WORDS (MAX_WORDS),
        .ROW_W     (ROW_W)
    ) u_table (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .row_we    (row_we),
        .row_waddr (used_eff[WIDX-1:0]),
        .row_wdata ({len_reg, cur_word_reg}),
        .cnt_we    (cnt_we),
        .cnt_waddr (cnt_waddr),
        .cnt_wdata (cnt_wdata),
        .row_q     (row_q),
        .cnt_q     (cnt_q)
    );

    wfc_compare #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS),
        .LW             (LW)
    ) u_compare (
        .row_len   (row_q[ROW_W-1 -: LW]),
        .row_chars (row_q[8*MAX_WORD_CHARS-1:0]),
        .cur_len   (len_reg),
        .cur_chars (cur_word_reg),
        .hit       (hit)
    );

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        used_next     = used_reg;
        char_we       = 1'b0;
        rd_addr       = '0;
        row_we        = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = scan_idx_reg;
        cnt_wdata     = wfc_pkg::sat_inc(cnt_q);
        do_miss       = 1'b0;
        fin           = 1'b0;
        fin_idx       = scan_idx_reg;
        fin_cnt       = wfc_pkg::sat_inc(cnt_q);
        fin_new       = 1'b0;
        fin_full      = 1'b0;

        unique case (state_reg)
            wfc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    used_next = used_eff;
                    len_next  = len_eff;
                    ovf_next  = ovf_eff;
                    if (!delim)
                    begin
                        if (len_eff < LW'(MAX_WORD_CHARS))
                        begin
                            char_we  = 1'b1;
                            len_next = len_eff + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (len_eff != '0)
                    begin
                        if (used_eff == '0)
                        begin
                            do_miss = 1'b1;
                        end
                        else
                        begin
                            rd_addr       = '0;
                            scan_idx_next = '0;
                            state_next    = wfc_pkg::ST_SCAN;
                        end
                    end
                end
            end
            wfc_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    cnt_we = 1'b1;
                    fin    = 1'b1;
                end
                else if (scan_nxt_cnt < used_reg)
                begin
                    rd_addr       = scan_nxt_cnt[WIDX-1:0];
                    scan_idx_next = scan_nxt_cnt[WIDX-1:0];
                end
                else
                begin
                    do_miss = 1'b1;
                end
            end
            default:
            begin
                state_next = wfc_pkg::ST_IDLE;
            end
        endcase

        // word not in table: append it, or drop it when full
        if (do_miss)
        begin
            fin      = 1'b1;
            row_we   = room;
            cnt_we   = room;
            cnt_waddr = used_eff[WIDX-1:0];
            cnt_wdata = 16'd1;
            fin_idx  = room ? used_eff[WIDX-1:0] : '0;
            fin_cnt  = room ? 16'd1 : 16'd0;
            fin_new  = room;
            fin_full = !room;
            if (room)
            begin
                used_next = used_eff + UW'(1);
            end
        end

        if (fin)
        begin
            len_next   = '0;
            ovf_next   = 1'b0;
            state_next = wfc_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wfc_pkg::ST_IDLE;
            scan_idx_reg <= '0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            used_reg     <= '0;
            nul_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            used_reg     <= used_next;
            done_reg     <= fin;
            if (psel && penable && pwrite && (paddr[2] == wfc_pkg::REG_NUL_IS_DELIMITER))
            begin
                nul_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            cur_word_reg[len_eff[CIW-1:0]] <= char_code;
        end
        if (fin)
        begin
            out_idx_reg   <= fin_idx;
            out_cnt_reg   <= fin_cnt;
            out_new_reg   <= fin_new;
            out_used_reg  <= used_next;
            out_full_reg  <= fin_full;
            out_trunc_reg <= ovf_eff;
        end
    end

    assign idx_ext  = {6'd0, out_idx_reg};
    assign used_ext = {7'd0, out_used_reg};

    assign done           = done_reg;
    assign word_index     = idx_ext[5:0];
    assign word_count     = out_cnt_reg;
    assign is_new         = out_new_reg;
    assign distinct_words = used_ext[6:0];
    assign table_full     = out_full_reg;
    assign truncated      = out_trunc_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == wfc_pkg::REG_NUL_IS_DELIMITER) ? {31'd0, nul_reg} : 32'd0;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfc_pkg::ST_SCAN) |-> (UW'(scan_idx_reg) < used_reg))
        else $error("scan index past table fill");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(MAX_WORDS))
        else $error("table fill above capacity");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (!is_new && (word_count == 16'd0)))
        else $error("dropped word reported as stored");

    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_new) |-> (word_count == 16'd1))
        else $error("new word count not one");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(accept)))
        else $error("result beat without a lookup");

endmodule

// ----- tb/word_frequency_checker.sv -----
`timescale 1ns / 100ps

module word_frequency_checker #(
    parameter int MAX_WORDS      = 64,
    parameter int MAX_WORD_CHARS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  char_code,
    input  logic        first_of_document,
    input  logic        done,
    input  logic [5:0]  word_index,
    input  logic [15:0] word_count,
    input  logic        is_new,
    input  logic [6:0]  distinct_words,
    input  logic        table_full,
    input  logic        truncated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          failures,
    output int          pending
);

    localparam int REPORT_LIMIT = 50;

    typedef struct packed {
        logic [5:0]      index;
        wfc_pkg::count_t count;
        logic            fresh;
        logic [6:0]      distinct;
        logic            full;
        logic            cut;
    } word_tally_t;

    word_tally_t expected_tallies[$];

    // model copy of the block state
    logic            nul_delim;
    wfc_pkg::char_t  cur_word [MAX_WORD_CHARS];
    logic [5:0]      cur_len;
    logic            cur_cut;
    wfc_pkg::char_t  entry_chars [MAX_WORDS][MAX_WORD_CHARS];
    logic [5:0]      entry_len [MAX_WORDS];
    wfc_pkg::count_t entry_count [MAX_WORDS];
    logic [6:0]      used;
    int              reported;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            if (reported < REPORT_LIMIT)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                reported++;
            end
        end
    endtask

    task automatic tally_byte(input wfc_pkg::char_t c, input logic fod);
        logic        is_delim_byte;
        logic        hit;
        logic        same;
        logic [5:0]  slot;
        word_tally_t t;
        if (fod)
        begin
            used    = '0;
            cur_len = '0;
            cur_cut = 1'b0;
        end
        is_delim_byte = (c == wfc_pkg::CH_SPACE) || (c == wfc_pkg::CH_LF) ||
                        (c == wfc_pkg::CH_CR) || (c == wfc_pkg::CH_PERIOD) ||
                        ((c == wfc_pkg::CH_NUL) && nul_delim);
        if (!is_delim_byte)
        begin
            if (cur_len < MAX_WORD_CHARS)
            begin
                cur_word[cur_len] = c;
                cur_len++;
            end
            else
                cur_cut = 1'b1;
            return;
        end
        if (cur_len == 0)
            return;

        hit  = 1'b0;
        slot = '0;
        for (int e = 0; e < used && !hit; e++)
        begin
            if (entry_len[e] == cur_len)
            begin
                same = 1'b1;
                for (int k = 0; k < cur_len; k++)
                    if (entry_chars[e][k] != cur_word[k])
                        same = 1'b0;
                if (same)
                begin
                    hit  = 1'b1;
                    slot = e[5:0];
                end
            end
        end

        t = '0;
        if (hit)
        begin
            if (entry_count[slot] != wfc_pkg::COUNT_MAX)
                entry_count[slot]++;
            t.index = slot;
            t.count = entry_count[slot];
        end
        else if (used < MAX_WORDS)
        begin
            slot = used[5:0];
            for (int k = 0; k < cur_len; k++)
                entry_chars[slot][k] = cur_word[k];
            entry_len[slot]   = cur_len;
            entry_count[slot] = 16'd1;
            used++;
            t.index = slot;
            t.count = 16'd1;
            t.fresh = 1'b1;
        end
        else
            t.full = 1'b1;
        t.distinct = used;
        t.cut      = cur_cut;
        expected_tallies.push_back(t);
        cur_len = '0;
        cur_cut = 1'b0;
    endtask

    always @(posedge clk)
    begin
        word_tally_t want;
        if (!rst_n)
        begin
            nul_delim = 1'b0;
            cur_len   = '0;
            cur_cut   = 1'b0;
            used      = '0;
            expected_tallies.delete();
        end
        else
        begin
            // results first: a beat leaving now belongs to an earlier byte
            if (done)
            begin
                if (expected_tallies.size() == 0)
                begin
                    failures++;
                    if (reported < REPORT_LIMIT)
                    begin
                        $error("result beat with no word pending, word_index %0d",
                               word_index);
                        reported++;
                    end
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    check_field("word_index", 32'(want.index), 32'(word_index));
                    check_field("word_count", 32'(want.count), 32'(word_count));
                    check_field("is_new", 32'(want.fresh), 32'(is_new));
                    check_field("distinct_words", 32'(want.distinct),
                                32'(distinct_words));
                    check_field("table_full", 32'(want.full), 32'(table_full));
                    check_field("truncated", 32'(want.cut), 32'(truncated));
                end
            end

            if (psel && penable && pready && paddr[2] == wfc_pkg::REG_NUL_IS_DELIMITER)
            begin
                if (pwrite)
                    nul_delim = pwdata[0];
                else
                    check_field("prdata", {31'b0, nul_delim}, prdata);
            end

            if (start && !busy)
                tally_byte(char_code, first_of_document);
        end
        pending = expected_tallies.size();
    end

endmodule

// ----- tb/word_frequency_counter_unit_tb.sv -----
`timescale 1ns / 100ps

module word_frequency_counter_unit_tb;

    localparam int MAX_WORDS      = 64;
    localparam int MAX_WORD_CHARS = 32;
    localparam int SETTLE_CYCLES  = MAX_WORDS + 8;
    localparam int QUIET_LIMIT    = 4000;
    localparam int VOCAB_MAX      = 100;
    localparam int WORD_MAX_LEN   = 40;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    wfc_pkg::char_t char_code;
    logic           first_of_document;
    logic           done;
    logic [5:0]     word_index;
    logic [15:0]    word_count;
    logic           is_new;
    logic [6:0]     distinct_words;
    logic           table_full;
    logic           truncated;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    int failures;
    int pending;
    int quiet_cycles;
    int burst_left;
    int items_sent;
    int doc_odds;
    bit pacing;
    bit nul_on;
    bit new_doc;

    wfc_pkg::char_t vocab [VOCAB_MAX][WORD_MAX_LEN];
    int             vocab_len [VOCAB_MAX];
    wfc_pkg::char_t stem [MAX_WORD_CHARS];

    word_frequency_counter_unit #(
        .MAX_WORDS      (MAX_WORDS),
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .char_code         (char_code),
        .first_of_document (first_of_document),
        .done              (done),
        .word_index        (word_index),
        .word_count        (word_count),
        .is_new            (is_new),
        .distinct_words    (distinct_words),
        .table_full        (table_full),
        .truncated         (truncated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    word_frequency_checker #(
        .MAX_WORDS      (MAX_WORDS),
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .char_code         (char_code),
        .first_of_document (first_of_document),
        .done              (done),
        .word_index        (word_index),
        .word_count        (word_count),
        .is_new            (is_new),
        .distinct_words    (distinct_words),
        .table_full        (table_full),
        .truncated         (truncated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .failures          (failures),
        .pending           (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // nothing moving for too long means the block hung
    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic wfc_pkg::char_t text_byte(input bit nul_delim);
        wfc_pkg::char_t c;
        c = wfc_pkg::char_t'($urandom_range(0, 255));
        while (c == wfc_pkg::CH_SPACE || c == wfc_pkg::CH_LF || c == wfc_pkg::CH_CR ||
               c == wfc_pkg::CH_PERIOD || (c == wfc_pkg::CH_NUL && nul_delim))
            c = wfc_pkg::char_t'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic wfc_pkg::char_t delim_byte(input bit nul_delim);
        case ($urandom_range(0, nul_delim ? 4 : 3))
            0:       return wfc_pkg::CH_SPACE;
            1:       return wfc_pkg::CH_LF;
            2:       return wfc_pkg::CH_CR;
            3:       return wfc_pkg::CH_PERIOD;
            default: return wfc_pkg::CH_NUL;
        endcase
    endfunction

    // one input beat; start stays high when the next beat follows at once
    task automatic send_byte(input wfc_pkg::char_t c, input logic fod);
        start             <= 1'b1;
        char_code         <= c;
        first_of_document <= fod;
        do @(posedge clk); while (busy);
        if (pacing)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6))
                    @(posedge clk);
                burst_left = $urandom_range(0, 24);
            end
            else
                burst_left--;
        end
    endtask

    task automatic text_item(input wfc_pkg::char_t c);
        logic fod;
        fod = new_doc || (doc_odds != 0 && $urandom_range(1, doc_odds) == 1);
        new_doc = 1'b0;
        send_byte(c, fod);
        items_sent++;
    endtask

    // wait until every word has come back and the block has gone quiet
    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_nul(input bit v);
        reg_access(1'b1, {wfc_pkg::REG_NUL_IS_DELIMITER, 2'b00},
                   ($urandom() & 32'hFFFF_FFFE) | {31'd0, v});
        // other index is not a register, must be ignored
        reg_access(1'b1, {~wfc_pkg::REG_NUL_IS_DELIMITER, 2'b00}, $urandom());
        reg_access(1'b0, {wfc_pkg::REG_NUL_IS_DELIMITER, 2'b00}, '0);
        nul_on = v;
    endtask

    // short words mostly; long ones share one stem so cut words collide
    task automatic make_vocab(input int n);
        for (int k = 0; k < MAX_WORD_CHARS; k++)
            stem[k] = text_byte(nul_on);
        for (int w = 0; w < n; w++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                vocab_len[w] = $urandom_range(MAX_WORD_CHARS - 2, WORD_MAX_LEN);
                for (int k = 0; k < vocab_len[w]; k++)
                    vocab[w][k] = (k < MAX_WORD_CHARS) ? stem[k] : text_byte(nul_on);
            end
            else
            begin
                vocab_len[w] = $urandom_range(1, 6);
                for (int k = 0; k < vocab_len[w]; k++)
                    vocab[w][k] = text_byte(nul_on);
            end
        end
    endtask

    task automatic emit_word(input int w);
        for (int k = 0; k < vocab_len[w]; k++)
            text_item(vocab[w][k]);
        // runs of delimiters make empty words
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1)
            text_item(delim_byte(nul_on));
    endtask

    task automatic run_phase(input bit v, input int n, input int quota,
                             input bit paced, input int odds);
        settle();
        set_nul(v);
        make_vocab(n);
        pacing     = paced;
        doc_odds   = odds;
        new_doc    = 1'b1;
        items_sent = 0;
        while (items_sent < quota)
        begin
            if ($urandom_range(0, 9) == 0)
                text_item(wfc_pkg::char_t'($urandom_range(0, 255)));
            else
                emit_word($urandom_range(0, n - 1));
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        char_code         = '0;
        first_of_document = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        burst_left        = 0;
        nul_on            = 1'b0;
        pacing            = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: leading and doubled delimiters, NUL as text, every delimiter
        send_byte(wfc_pkg::CH_SPACE, 1'b1);
        send_byte("a", 1'b0);
        send_byte(wfc_pkg::CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(wfc_pkg::CH_SPACE, 1'b0);
        send_byte(wfc_pkg::CH_LF, 1'b0);
        send_byte("a", 1'b0);
        send_byte(wfc_pkg::CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(wfc_pkg::CH_CR, 1'b0);
        send_byte("b", 1'b0);
        send_byte(wfc_pkg::CH_PERIOD, 1'b0);
        settle();
        set_nul(1'b1);
        // NUL now ends words; then a new document mid-stream
        send_byte("a", 1'b0);
        send_byte(wfc_pkg::CH_NUL, 1'b0);
        send_byte(wfc_pkg::CH_NUL, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(wfc_pkg::CH_PERIOD, 1'b0);

        run_phase(1'b0, 12, 350, 1'b1, 100);
        // many distinct words in one document to overflow the table
        run_phase(1'b1, VOCAB_MAX, 700, 1'b1, 0);
        run_phase(1'($urandom_range(0, 1)), 6, 250, 1'b0, 60);
        run_phase(1'($urandom_range(0, 1)), 20, 450, 1'b1, 120);

        settle();
        if (failures == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
